[hw/rtl/cht_pkg.sv]
// Package for the C header tokenizer: item types, context record, lexer modes,
// keyword table and byte class functions. Depends on nothing.
package cht_pkg;

  localparam int unsigned PosWidth    = 32;
  localparam int unsigned MaxKwLen    = 23;
  localparam int unsigned KwCount     = 41;
  localparam int unsigned KwLenWidth  = 5;
  localparam int unsigned ValWidth    = 63;
  localparam int unsigned MaxResults  = 3;
  localparam int unsigned QueueDepth  = 4;

  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChStar      = 8'h2A;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChZero      = 8'h30;

  typedef enum logic [2:0] {
    KindNewline = 3'd0,
    KindKeyword = 3'd1,
    KindIdent   = 3'd2,
    KindInt     = 3'd3,
    KindString  = 3'd4,
    KindSymbol  = 3'd5,
    KindError   = 3'd6
  } kind_e;

  typedef enum logic [2:0] {
    ModeIdle  = 3'd0,
    ModeSlash = 3'd1,
    ModeIdent = 3'd2,
    ModeInt   = 3'd3,
    ModeStr   = 3'd4,
    ModeLcomm = 3'd5,
    ModeBcomm = 3'd6,
    ModeError = 3'd7
  } mode_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]          token_kind;
    logic [5:0]          keyword_index;
    logic [7:0]          symbol_char;
    logic [ValWidth-1:0] int_value;
    logic [31:0]         token_start;
    logic [31:0]         token_length;
    logic                result_last;
  } token_t;

  // Lexer context kept in the context memory.
  typedef struct packed {
    mode_e               mode;
    logic [PosWidth-1:0] pos;
    logic [PosWidth-1:0] start;
    logic [KwCount-1:0]  cands;
    logic [ValWidth-1:0] acc;
    logic                ovf;
    logic [7:0]          quote;
    logic                esc;
    logic [7:0]          prev;
  } ctx_t;

  // Keywords, right-justified in 23 bytes. Some entries are given as ASCII
  // byte codes, first character in the highest byte.
  localparam logic [8*MaxKwLen-1:0] KwText [KwCount] = '{
    "include", "struct", "typedef", "class", "enum", "define", "public",
    "private", "const", "void", "char",
    64'h6368_6172_3136_5f74,
    64'h6368_6172_3332_5f74,
    "unsigned",
    "signed", "short", "long", "ulong", "int", "int8_t", "int16_t", "int32_t",
    "int64_t", "uint8_t",
    64'h7569_6e74_3136_5f74,
    64'h7569_6e74_3332_5f74,
    64'h7569_6e74_3634_5f74,
    "float", "double",
    "if", "ifdef", "ifndef", "endif", "extern", "pragma", "once",
    184'h424C495F_53544154_49435F41_53534552_545F414C_49474E,
    176'h444E415F_44454649_4E455F43_58585F4D_4554484F_4453,
    112'h444E415F_44455052_45434154_4544,
    160'h444E415F_44455052_45434154_45445F41_4C4C4F57,
    112'h454E554D_5F4F5045_5241544F_5253
  };

  localparam logic [KwLenWidth-1:0] KwLen [KwCount] = '{
    5'd7, 5'd6, 5'd7, 5'd5, 5'd4, 5'd6, 5'd6, 5'd7, 5'd5, 5'd4, 5'd4, 5'd8, 5'd8,
    5'd8, 5'd6, 5'd5, 5'd4, 5'd5, 5'd3, 5'd6, 5'd7, 5'd7, 5'd7, 5'd7, 5'd8, 5'd8,
    5'd8, 5'd5, 5'd6, 5'd2, 5'd5, 5'd6, 5'd5, 5'd6, 5'd6, 5'd4, 5'd23, 5'd22,
    5'd14, 5'd20, 5'd14
  };

  function automatic ctx_t ctx_reset();
    ctx_t s;
    s       = '0;
    s.mode  = ModeIdle;
    s.cands = '1;
    return s;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c inside {[8'h61:8'h7A]}) || (c inside {[8'h41:8'h5A]}) || (c == 8'h5F);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_symbol(logic [7:0] c);
    return c inside {":", ";", "(", ")", "[", "]", "{", "}", "=", "#", ".", ",",
                     "*", "<", ">", "|", "&", "+", "-", "!", "%", "^", "?", "~",
                     ChBackslash, ChSlash};
  endfunction

endpackage

[hw/rtl/cht_ctx_mem.sv]
// Single-context state memory with a registered read port and write forwarding.
// Depends on cht_pkg.
module cht_ctx_mem (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  cht_pkg::ctx_t wdata_i,
  output cht_pkg::ctx_t rdata_o
);
  import cht_pkg::*;

  localparam int unsigned CtxDepth = 1;

  ctx_t mem_q [CtxDepth];
  ctx_t rd_q;
  logic vld_q;

  // Storage array, written on every accepted item.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[0] <= wdata_i;
    end
  end

  // Registered read; a write in the same cycle is forwarded.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      rd_q <= wdata_i;
    end else begin
      rd_q <= mem_q[0];
    end
  end

  // The entry reads as the reset context until the first write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (we_i) begin
      vld_q <= 1'b1;
    end
  end

  assign rdata_o = vld_q ? rd_q : ctx_reset();

endmodule

[hw/rtl/cht_lex.sv]
// Per-byte lexer step: modifies the context read from the context memory and
// produces up to three tokens. Depends on cht_pkg.
module cht_lex (
  input  cht_pkg::ctx_t    ctx_i,
  input  cht_pkg::in_item_t item_i,
  output cht_pkg::ctx_t    ctx_o,
  output cht_pkg::token_t  tok_o [cht_pkg::MaxResults],
  output logic [1:0]       tok_cnt_o
);
  import cht_pkg::*;

  typedef struct packed {
    ctx_t   s;
    logic   v;
    token_t t;
  } disp_t;

  function automatic token_t mk_tok(kind_e k, logic [5:0] kwi, logic [7:0] sym,
                                    logic [ValWidth-1:0] val,
                                    logic [PosWidth-1:0] st,
                                    logic [PosWidth-1:0] len);
    token_t t;
    t.token_kind    = k;
    t.keyword_index = kwi;
    t.symbol_char   = sym;
    t.int_value     = val;
    t.token_start   = 32'(st);
    t.token_length  = 32'(len);
    t.result_last   = 1'b0;
    return t;
  endfunction

  // Drop keyword candidates whose character at this offset differs.
  function automatic ctx_t narrow(ctx_t s, logic [7:0] c, logic [PosWidth-1:0] p);
    logic [PosWidth-1:0] k;
    logic [7:0]          kc;
    k = p - s.start;
    if (k >= PosWidth'(MaxKwLen)) begin
      s.cands = '0;
    end else begin
      for (int i = 0; i < KwCount; i++) begin
        kc = 8'(KwText[i] >> (8 * (32'(KwLen[i]) - 1 - 32'(k))));
        if (k >= PosWidth'(KwLen[i]) || kc != c) begin
          s.cands[i] = 1'b0;
        end
      end
    end
    return s;
  endfunction

  // Accumulate one decimal digit; exceeding 2^63-1 marks overflow.
  function automatic ctx_t add_digit(ctx_t s, logic [7:0] c);
    logic [ValWidth+3:0] prod;
    if (!s.ovf) begin
      prod = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1) + (ValWidth+4)'(c - ChZero);
      if (prod[ValWidth+3:ValWidth] != '0) begin
        s.ovf = 1'b1;
        s.acc = '0;
      end else begin
        s.acc = prod[ValWidth-1:0];
      end
    end
    return s;
  endfunction

  function automatic token_t finish_ident(ctx_t s, logic [PosWidth-1:0] e);
    logic [PosWidth-1:0] len;
    token_t              t;
    len = e - s.start;
    t   = mk_tok(KindIdent, 6'd0, 8'd0, '0, s.start, len);
    // Lowest matching table index wins.
    for (int i = KwCount - 1; i >= 0; i--) begin
      if (s.cands[i] && PosWidth'(KwLen[i]) == len) begin
        t = mk_tok(KindKeyword, 6'(i), 8'd0, '0, s.start, len);
      end
    end
    return t;
  endfunction

  function automatic token_t finish_int(ctx_t s, logic [PosWidth-1:0] e);
    return mk_tok(KindInt, 6'd0, 8'd0, s.ovf ? '0 : s.acc, s.start, e - s.start);
  endfunction

  // Start of a new token from the idle mode.
  function automatic disp_t dispatch(ctx_t s, logic [7:0] c, logic [PosWidth-1:0] p);
    disp_t d;
    d.v    = 1'b0;
    d.t    = '0;
    s.mode = ModeIdle;
    if (is_blank(c)) begin
      d.v = 1'b0;
    end else if (c == ChSlash) begin
      s.mode  = ModeSlash;
      s.start = p;
    end else if (is_alpha(c)) begin
      s.mode  = ModeIdent;
      s.start = p;
      s.cands = '1;
      s       = narrow(s, c, p);
    end else if (is_digit(c)) begin
      s.mode  = ModeInt;
      s.start = p;
      s.acc   = '0;
      s.ovf   = 1'b0;
      s       = add_digit(s, c);
    end else if (c == ChDquote || c == ChSquote) begin
      s.mode  = ModeStr;
      s.start = p;
      s.quote = c;
      s.esc   = 1'b0;
    end else if (is_symbol(c)) begin
      d.v = 1'b1;
      d.t = mk_tok(KindSymbol, 6'd0, c, '0, p, PosWidth'(1));
    end else if (c == ChNewline) begin
      d.v = 1'b1;
      d.t = mk_tok(KindNewline, 6'd0, 8'd0, '0, p, PosWidth'(1));
    end else begin
      d.v    = 1'b1;
      d.t    = mk_tok(KindError, 6'd0, c, '0, p, PosWidth'(1));
      s.mode = ModeError;
    end
    d.s = s;
    return d;
  endfunction

  // Step logic for one byte.
  always_comb begin
    ctx_t                s;
    disp_t               d;
    logic [7:0]          c;
    logic [PosWidth-1:0] p;
    logic [PosWidth-1:0] e;
    logic [1:0]          n;
    token_t              r [MaxResults];

    s = ctx_i;
    c = item_i.in_byte;
    p = ctx_i.pos;
    e = p + PosWidth'(1);
    n = 2'd0;
    d = '0;
    for (int i = 0; i < MaxResults; i++) begin
      r[i] = '0;
    end

    case (s.mode)
      ModeIdle: begin
        d = dispatch(s, c, p);
        s = d.s;
        if (d.v) begin r[n] = d.t; n = n + 2'd1; end
      end
      ModeSlash: begin
        if (c == ChSlash) begin
          s.mode = ModeLcomm;
        end else if (c == ChStar) begin
          s.mode = ModeBcomm;
          s.prev = ChSlash;
        end else begin
          r[n] = mk_tok(KindSymbol, 6'd0, ChSlash, '0, s.start, PosWidth'(1));
          n    = n + 2'd1;
          d    = dispatch(s, c, p);
          s    = d.s;
          if (d.v) begin r[n] = d.t; n = n + 2'd1; end
        end
      end
      ModeIdent: begin
        if (is_alpha(c) || is_digit(c)) begin
          s = narrow(s, c, p);
        end else begin
          r[n] = finish_ident(s, p);
          n    = n + 2'd1;
          d    = dispatch(s, c, p);
          s    = d.s;
          if (d.v) begin r[n] = d.t; n = n + 2'd1; end
        end
      end
      ModeInt: begin
        if (is_digit(c)) begin
          s = add_digit(s, c);
        end else begin
          r[n] = finish_int(s, p);
          n    = n + 2'd1;
          d    = dispatch(s, c, p);
          s    = d.s;
          if (d.v) begin r[n] = d.t; n = n + 2'd1; end
        end
      end
      ModeStr: begin
        if (!s.esc && c == s.quote) begin
          r[n]   = mk_tok(KindString, 6'd0, 8'd0, '0, s.start, e - s.start);
          n      = n + 2'd1;
          s.mode = ModeIdle;
        end else begin
          s.esc = (c == ChBackslash) && !s.esc;
        end
      end
      ModeLcomm: begin
        if (c == ChNewline) begin
          d = dispatch(s, c, p);
          s = d.s;
          if (d.v) begin r[n] = d.t; n = n + 2'd1; end
        end
      end
      ModeBcomm: begin
        if (s.prev == ChStar && c == ChSlash) begin
          s.mode = ModeIdle;
        end else begin
          s.prev = c;
        end
      end
      ModeError: begin
        s.mode = ModeError;
      end
      default: begin
        d = dispatch(s, c, p);
        s = d.s;
        if (d.v) begin r[n] = d.t; n = n + 2'd1; end
      end
    endcase

    // End of text closes any open token and returns to the reset context.
    if (item_i.in_last) begin
      case (s.mode)
        ModeIdent: begin r[n] = finish_ident(s, e); n = n + 2'd1; end
        ModeInt:   begin r[n] = finish_int(s, e); n = n + 2'd1; end
        ModeSlash: begin
          r[n] = mk_tok(KindSymbol, 6'd0, ChSlash, '0, s.start, PosWidth'(1));
          n    = n + 2'd1;
        end
        ModeStr: begin
          r[n] = mk_tok(KindError, 6'd0, s.quote, '0, s.start, PosWidth'(1));
          n    = n + 2'd1;
        end
        default: begin
          n = n;
        end
      endcase
      s = ctx_reset();
    end else begin
      s.pos = e;
    end

    if (n != 2'd0) begin
      r[n - 2'd1].result_last = 1'b1;
    end

    ctx_o     = s;
    tok_o     = r;
    tok_cnt_o = n;
  end

endmodule

[hw/rtl/cht_tok_fifo.sv]
// Token queue: takes up to three tokens per cycle, hands out one per cycle while the reader is ready.
// Depends on cht_pkg.
module cht_tok_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cht_pkg::token_t push_tok_i [cht_pkg::MaxResults],
  input  logic [1:0]      push_cnt_i,
  output logic            room_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cht_pkg::token_t out_data_o
);
  import cht_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  token_t          buf_q [QueueDepth];
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = buf_q[rp_q];
  assign room_o      = (CntW'(QueueDepth) - cnt_q) >= CntW'(MaxResults);

  // Pointer and fill count update.
  always_comb begin
    wp_d  = wp_q + PtrW'(push_cnt_i);
    rp_d  = rp_q + PtrW'(pop);
    cnt_d = cnt_q + CntW'(push_cnt_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Token storage, written in order from the write pointer.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxResults; i++) begin
      if (2'(i) < push_cnt_i) begin
        buf_q[wp_q + PtrW'(i)] <= push_tok_i[i];
      end
    end
  end

endmodule

[hw/rtl/c_header_tokenizer.sv]
// C header tokenizer: one text byte per cycle in, tokens out in order.
// A token enters the token queue when the byte that ends it is accepted.
// Throughput: one byte per cycle while the four-entry token queue has room for
// three tokens; bursts of several tokens per byte drain at one per ready cycle.
// The context memory is read and rewritten each byte with write forwarding.
// Reset: asynchronous, active low; the queue empties and the context is idle.
module c_header_tokenizer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cht_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cht_pkg::token_t   out_data_o
);
  import cht_pkg::*;

  ctx_t       ctx_rd, ctx_wr;
  token_t     toks [MaxResults];
  logic [1:0] tok_cnt;
  logic       room, accept;

  assign in_ready_o = room;
  assign accept     = in_valid_i && in_ready_o;

  // Context storage.
  cht_ctx_mem u_ctx_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (accept),
    .wdata_i (ctx_wr),
    .rdata_o (ctx_rd)
  );

  // Byte step.
  cht_lex u_lex (
    .ctx_i     (ctx_rd),
    .item_i    (in_data_i),
    .ctx_o     (ctx_wr),
    .tok_o     (toks),
    .tok_cnt_o (tok_cnt)
  );

  // Output queue; pushes only on accepted items.
  cht_tok_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_tok_i  (toks),
    .push_cnt_i  (accept ? tok_cnt : 2'd0),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[hw/rtl/cht_checker.sv]
// Port-level checks for the C header tokenizer, bound to the top level.
// Depends on cht_pkg and c_header_tokenizer.
module cht_props (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input cht_pkg::token_t   out_data_o
);
  import cht_pkg::*;

  // A stalled token holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled token changed");

  // Kinds stay in the defined range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.token_kind <= 3'(KindError))
    else $error("undefined token kind");

  // Single-byte kinds have length one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.token_kind == 3'(KindNewline) ||
                    out_data_o.token_kind == 3'(KindSymbol) ||
                    out_data_o.token_kind == 3'(KindError))
    |-> out_data_o.token_length == 32'd1)
    else $error("single-byte token with wrong length");

  // Only keywords carry a keyword number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.token_kind != 3'(KindKeyword)
    |-> out_data_o.keyword_index == 6'd0)
    else $error("keyword number on non-keyword");

endmodule

bind c_header_tokenizer cht_props u_cht_props (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

[tb/cht_checker.sv]
// Checker for the C header tokenizer: watches both item channels, predicts the
// token stream byte by byte and compares every token. Depends on cht_pkg.
`timescale 1ns / 1ps
module cht_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  cht_pkg::in_item_t in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  cht_pkg::token_t   out_data_i,
  output int                fail_count_o,
  output int                pending_o
);
  import cht_pkg::*;

  // Predicted lexer state.
  mode_e        lx_mode;
  logic [31:0]  lx_pos;
  logic [31:0]  lx_start;
  logic [40:0]  lx_cands;
  logic [63:0]  lx_acc;
  logic         lx_ovf;
  logic [7:0]   lx_quote;
  logic         lx_esc;
  logic [7:0]   lx_prev;

  token_t expected_tokens[$];
  token_t byte_tokens[$];

  assign pending_o = expected_tokens.size();

  task automatic clear_lexer();
    lx_mode  = ModeIdle;
    lx_pos   = '0;
    lx_start = '0;
    lx_cands = '1;
    lx_acc   = '0;
    lx_ovf   = 1'b0;
    lx_quote = '0;
    lx_esc   = 1'b0;
    lx_prev  = '0;
  endtask

  function automatic logic blank_byte(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
  endfunction

  function automatic logic letter_byte(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic digit_byte(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic punct_byte(logic [7:0] c);
    case (c)
      ":", ";", "(", ")", "[", "]", "{", "}", "=", "#", ".", ",", "*", "<", ">",
      "|", "&", "+", "-", "!", "%", "^", "?", "~", ChBackslash, ChSlash: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic emit(kind_e kind, logic [5:0] kwi, logic [7:0] sym,
                      logic [62:0] val, logic [31:0] start, logic [31:0] len);
    token_t t;
    if (byte_tokens.size() < MaxResults) begin
      t.token_kind    = kind;
      t.keyword_index = kwi;
      t.symbol_char   = sym;
      t.int_value     = val;
      t.token_start   = start;
      t.token_length  = len;
      t.result_last   = 1'b0;
      byte_tokens.push_back(t);
    end
  endtask

  // Drop keywords whose character at this offset differs.
  task automatic narrow_keywords(logic [7:0] c, logic [31:0] p);
    logic [31:0] k;
    int unsigned n;
    k = p - lx_start;
    if (k >= MaxKwLen) begin
      lx_cands = '0;
    end else begin
      for (int i = 0; i < KwCount; i++) begin
        n = KwLen[i];
        if (k >= n || KwText[i][8*(n-1-k) +: 8] != c) lx_cands[i] = 1'b0;
      end
    end
  endtask

  task automatic close_word(logic [31:0] endpos);
    logic [31:0] len;
    len = endpos - lx_start;
    for (int i = 0; i < KwCount; i++) begin
      if (lx_cands[i] && KwLen[i] == len) begin
        emit(KindKeyword, 6'(i), 8'h00, '0, lx_start, len);
        return;
      end
    end
    emit(KindIdent, 6'd0, 8'h00, '0, lx_start, len);
  endtask

  task automatic close_number(logic [31:0] endpos);
    emit(KindInt, 6'd0, 8'h00, lx_ovf ? 63'd0 : lx_acc[62:0], lx_start, endpos - lx_start);
  endtask

  task automatic add_decimal(logic [7:0] c);
    logic [63:0] d;
    logic [63:0] lim;
    d   = 64'(c - ChZero);
    lim = 64'h7FFF_FFFF_FFFF_FFFF;
    if (!lx_ovf) begin
      if (lx_acc > (lim - d) / 10) begin
        lx_ovf = 1'b1;
        lx_acc = '0;
      end else begin
        lx_acc = lx_acc * 10 + d;
      end
    end
  endtask

  // Start of a token from the idle state.
  task automatic start_token(logic [7:0] c, logic [31:0] p);
    lx_mode = ModeIdle;
    if (blank_byte(c)) begin
      return;
    end
    if (c == ChSlash) begin
      lx_mode  = ModeSlash;
      lx_start = p;
    end else if (letter_byte(c)) begin
      lx_mode  = ModeIdent;
      lx_start = p;
      lx_cands = '1;
      narrow_keywords(c, p);
    end else if (digit_byte(c)) begin
      lx_mode  = ModeInt;
      lx_start = p;
      lx_acc   = '0;
      lx_ovf   = 1'b0;
      add_decimal(c);
    end else if (c == ChDquote || c == ChSquote) begin
      lx_mode  = ModeStr;
      lx_start = p;
      lx_quote = c;
      lx_esc   = 1'b0;
    end else if (punct_byte(c)) begin
      emit(KindSymbol, 6'd0, c, '0, p, 32'd1);
    end else if (c == ChNewline) begin
      emit(KindNewline, 6'd0, 8'h00, '0, p, 32'd1);
    end else begin
      emit(KindError, 6'd0, c, '0, p, 32'd1);
      lx_mode = ModeError;
    end
  endtask

  // Advance the lexer by one byte and queue the tokens it yields.
  task automatic lex_byte(in_item_t item);
    logic [7:0]  c;
    logic [31:0] p;
    c = item.in_byte;
    p = lx_pos;
    byte_tokens.delete();
    case (lx_mode)
      ModeIdle: start_token(c, p);
      ModeSlash: begin
        if (c == ChSlash) begin
          lx_mode = ModeLcomm;
        end else if (c == ChStar) begin
          lx_mode = ModeBcomm;
          lx_prev = ChSlash;
        end else begin
          emit(KindSymbol, 6'd0, ChSlash, '0, lx_start, 32'd1);
          start_token(c, p);
        end
      end
      ModeIdent: begin
        if (letter_byte(c) || digit_byte(c)) begin
          narrow_keywords(c, p);
        end else begin
          close_word(p);
          start_token(c, p);
        end
      end
      ModeInt: begin
        if (digit_byte(c)) begin
          add_decimal(c);
        end else begin
          close_number(p);
          start_token(c, p);
        end
      end
      ModeStr: begin
        if (!lx_esc && c == lx_quote) begin
          emit(KindString, 6'd0, 8'h00, '0, lx_start, p + 1 - lx_start);
          lx_mode = ModeIdle;
        end else begin
          lx_esc = (c == ChBackslash) && !lx_esc;
        end
      end
      ModeLcomm: begin
        if (c == ChNewline) start_token(c, p);
      end
      ModeBcomm: begin
        if (lx_prev == ChStar && c == ChSlash) lx_mode = ModeIdle;
        else lx_prev = c;
      end
      default: ;
    endcase

    if (item.in_last) begin
      case (lx_mode)
        ModeIdent: close_word(p + 1);
        ModeInt:   close_number(p + 1);
        ModeSlash: emit(KindSymbol, 6'd0, ChSlash, '0, lx_start, 32'd1);
        ModeStr:   emit(KindError, 6'd0, lx_quote, '0, lx_start, 32'd1);
        default: ;
      endcase
      clear_lexer();
    end else begin
      lx_pos = p + 1;
    end

    if (byte_tokens.size() > 0) byte_tokens[byte_tokens.size()-1].result_last = 1'b1;
    foreach (byte_tokens[i]) expected_tokens.push_back(byte_tokens[i]);
  endtask

  // Compare tokens first, then predict from the byte of the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    token_t exp_tok;
    if (!rst_ni) begin
      clear_lexer();
      expected_tokens.delete();
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected token %p", $time, out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_tok = expected_tokens.pop_front();
          if (out_data_i.token_kind !== exp_tok.token_kind ||
              out_data_i.keyword_index !== exp_tok.keyword_index ||
              out_data_i.symbol_char !== exp_tok.symbol_char ||
              out_data_i.int_value !== exp_tok.int_value ||
              out_data_i.token_start !== exp_tok.token_start ||
              out_data_i.token_length !== exp_tok.token_length ||
              out_data_i.result_last !== exp_tok.result_last) begin
            $display("%0t: token mismatch expected %p actual %p", $time, exp_tok,
                     out_data_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) lex_byte(in_data_i);
    end
  end

endmodule

[tb/tb_top.sv]
// Top of the tokenizer testbench: clock, reset, byte stimulus and verdict.
// Depends on cht_pkg, c_header_tokenizer and cht_checker.
`timescale 1ns / 1ps
module tb_top;
  import cht_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_item_t in_data;
  logic     out_valid;
  logic     out_ready;
  token_t   out_data;
  int       fail_count;
  int       pending;
  int       cycles;
  int       send_idle_pct;
  int       recv_idle_pct;
  logic     hold_req;
  int       bytes_sent;

  c_header_tokenizer u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  cht_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    int held;
    if (!rst_n) begin
      out_ready <= 1'b0;
      held = 0;
    end else if (hold_req && held < HoldCycles) begin
      out_ready <= 1'b0;
      held++;
    end else begin
      if (!hold_req) held = 0;
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one byte and wait until it is taken; valid stays up afterwards.
  task automatic send_byte(logic [7:0] b, logic last);
    logic rdy;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid        <= 1'b1;
    in_data.in_byte <= b;
    in_data.in_last <= last;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    bytes_sent++;
  endtask

  task automatic send_text(logic [7:0] txt[$]);
    foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
  endtask

  function automatic void push_str(ref logic [7:0] txt[$], input string s);
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endfunction

  function automatic logic [7:0] word_char(bit first);
    int r;
    r = $urandom_range(first ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  // Build one random text from token-shaped fragments.
  function automatic void make_text(ref logic [7:0] txt[$]);
    string syms;
    int    n;
    int    L;
    syms = ":;()[]{}=#.,*<>|&+-!%^?~\\/";
    n = $urandom_range(2, 7);
    for (int f = 0; f < n; f++) begin
      case ($urandom_range(15))
        0, 1: begin
          n = n;
          L = $urandom_range(KwCount - 1);
          for (int k = 0; k < KwLen[L]; k++)
            txt.push_back(KwText[L][8*(KwLen[L]-1-k) +: 8]);
        end
        2, 3: begin
          L = $urandom_range(1, ($urandom_range(9) == 0) ? 30 : 6);
          for (int k = 0; k < L; k++) txt.push_back(word_char(k == 0));
        end
        4, 5: begin
          case ($urandom_range(5))
            0: push_str(txt, "9223372036854775807");
            1: push_str(txt, "9223372036854775808");
            2: push_str(txt, "99999999999999999999999");
            default: begin
              L = $urandom_range(1, 8);
              for (int k = 0; k < L; k++) txt.push_back(8'("0" + $urandom_range(9)));
            end
          endcase
        end
        6: begin
          L = $urandom_range(1) ? ChDquote : ChSquote;
          txt.push_back(8'(L));
          repeat ($urandom_range(5)) begin
            case ($urandom_range(4))
              0: txt.push_back(ChBackslash);
              1: txt.push_back(8'(L));
              default: txt.push_back(word_char(0));
            endcase
          end
          if (txt[txt.size()-1] == ChBackslash) txt.push_back(ChBackslash);
          txt.push_back(8'(L));
        end
        7: begin
          push_str(txt, "//");
          repeat ($urandom_range(4)) txt.push_back(8'($urandom_range(32, 126)));
          txt.push_back(ChNewline);
        end
        8: begin
          push_str(txt, "/*");
          repeat ($urandom_range(4)) txt.push_back($urandom_range(1) ? ChStar : word_char(0));
          push_str(txt, "*/");
        end
        9, 10: begin
          repeat ($urandom_range(1, 3)) txt.push_back(syms[$urandom_range(syms.len() - 1)]);
        end
        11: txt.push_back(ChNewline);
        12, 13: begin
          case ($urandom_range(4))
            0: txt.push_back(8'h09);
            1: txt.push_back(8'h0B);
            2: txt.push_back(8'h0C);
            3: txt.push_back(8'h0D);
            default: txt.push_back(8'h20);
          endcase
        end
        14: txt.push_back(ChSlash);
        default: begin
          // Rare stray byte from the whole range.
          if ($urandom_range(5) == 0) txt.push_back(8'($urandom_range(255)));
          else txt.push_back(8'h20);
        end
      endcase
    end
    // Sometimes cut the text short to leave a string or comment open.
    if ($urandom_range(9) == 0 && txt.size() > 1) begin
      L = $urandom_range(1, txt.size());
      while (txt.size() > L) void'(txt.pop_back());
    end
  endfunction

  // One phase of random texts; with press set, the receiver holds off once
  // after about twenty bytes while the sender keeps offering.
  task automatic random_phase(int sender_pct, int receiver_pct, int goal, bit press);
    logic [7:0] txt[$];
    int start_count;
    bit pressed;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    start_count   = bytes_sent;
    pressed       = 1'b0;
    while (bytes_sent - start_count < goal) begin
      if (press && !pressed && bytes_sent - start_count >= 20) begin
        hold_req = 1'b1;
        pressed  = 1'b1;
      end
      txt.delete();
      make_text(txt);
      send_text(txt);
    end
    hold_req = 1'b0;
  endtask

  initial begin
    logic [7:0] txt[$];
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    hold_req      = 1'b0;
    bytes_sent    = 0;
    send_idle_pct = 35;
    recv_idle_pct = 62;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed texts: keyword then a trailing slash, unterminated string with an
    // escaped quote, digits running into letters, comment that cannot reuse its
    // opening star, unknown byte followed by ignored bytes, line comment then an
    // open quote at the end.
    txt = {"i", "f", ChSlash};
    send_text(txt);
    txt = {ChDquote, "a", ChBackslash, ChDquote};
    send_text(txt);
    txt = {"1", "2", "a", "b"};
    send_text(txt);
    txt = {ChSlash, ChStar, ChSlash, ChStar, ChSlash, "x"};
    send_text(txt);
    txt = {8'hFF, 8'h00};
    send_text(txt);
    txt = {ChSlash, ChSlash, "c", ChNewline, ChSquote};
    send_text(txt);

    random_phase(35, 62, 130, 1'b0);
    random_phase(62, 35, 130, 1'b0);
    random_phase(0, 0, 130, 1'b1);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
